[hdl/kvrp_pkg.sv]
// Shared types, constants and helpers for the key/value record byte parser.
// No dependencies; every other file of the parser uses this package.
package kvrp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned VBYTE_W = 4;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LANES   = VALUE_W / BYTE_W;
    localparam int unsigned LANE_W  = $clog2(LANES);

    // longest string a length byte may announce; larger lengths clamp here
    localparam logic [BYTE_W-1:0] MAX_STR_LEN = 8'hFE;

    localparam logic [VBYTE_W-1:0] VBYTES_RESET = 4'd2;
    localparam logic [VBYTE_W-1:0] VBYTES_MIN   = 4'd2;
    localparam logic [VBYTE_W-1:0] VBYTES_MAX   = 4'd8;

    // record phases, which double as the field kind codes
    localparam logic [KIND_W-1:0] PH_NAME_LEN = 3'd0;
    localparam logic [KIND_W-1:0] PH_NAME     = 3'd1;
    localparam logic [KIND_W-1:0] PH_VALUE    = 3'd2;
    localparam logic [KIND_W-1:0] PH_UNIT_LEN = 3'd3;
    localparam logic [KIND_W-1:0] PH_UNIT     = 3'd4;
    localparam logic [KIND_W-1:0] PH_DESC_LEN = 3'd5;
    localparam logic [KIND_W-1:0] PH_DESC     = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]  phase;
        logic [BYTE_W-1:0]  remaining;
        logic [BYTE_W-1:0]  position;
        logic [VALUE_W-1:0] acc;
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  field_kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [BYTE_W-1:0]  byte_index;
        logic               value_done;
        logic [VALUE_W-1:0] record_value;
        logic               record_end;
    } t_result;

    function automatic logic [BYTE_W-1:0] clamp_len(input logic [BYTE_W-1:0] b);
        return (b > MAX_STR_LEN) ? MAX_STR_LEN : b;
    endfunction

    function automatic logic [VBYTE_W-1:0] eff_vbytes(input logic [VBYTE_W-1:0] v);
        logic [VBYTE_W-1:0] r;
        r = v;
        if (v < VBYTES_MIN) r = VBYTES_MIN;
        else if (v > VBYTES_MAX) r = VBYTES_MAX;
        return r;
    endfunction

endpackage

[hdl/kvrp_in_if.sv]
// Input channel of the record parser: one stream byte per word.
// Depends on kvrp_pkg for the byte width.
interface kvrp_in_if;
    logic                       valid;
    logic                       ready;
    logic [kvrp_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[hdl/kvrp_out_if.sv]
// Result channel of the record parser: one tagged result per word.
// Depends on kvrp_pkg for field widths.
interface kvrp_out_if;
    logic                         valid;
    logic                         ready;
    logic [kvrp_pkg::KIND_W-1:0]  field_kind;
    logic [kvrp_pkg::BYTE_W-1:0]  data_byte;
    logic [kvrp_pkg::BYTE_W-1:0]  byte_index;
    logic                         value_done;
    logic [kvrp_pkg::VALUE_W-1:0] record_value;
    logic                         record_end;

    modport source (output valid, output field_kind, output data_byte, output byte_index,
                    output value_done, output record_value, output record_end,
                    input ready);
    modport sink   (input valid, input field_kind, input data_byte, input byte_index,
                    input value_done, input record_value, input record_end,
                    output ready);
endinterface

[hdl/kvrp_step.sv]
// Per-byte decode: next parser state and the result for one stream byte.
// Purely combinational; depends on kvrp_pkg.
module kvrp_step (
    input  kvrp_pkg::t_state                i_state,
    input  logic [kvrp_pkg::BYTE_W-1:0]     i_byte,
    input  logic [kvrp_pkg::VBYTE_W-1:0]    i_vbytes,
    output kvrp_pkg::t_state                o_next,
    output kvrp_pkg::t_result               o_res
);

    logic [kvrp_pkg::BYTE_W-1:0]   len;
    logic [kvrp_pkg::BYTE_W-1:0]   rem_dec;
    logic [kvrp_pkg::LANE_W-1:0]   lane;
    logic [kvrp_pkg::VALUE_W-1:0]  acc_new;
    logic [kvrp_pkg::BYTE_W:0]     pos_inc;
    logic                          val_last;
    logic [kvrp_pkg::KIND_W-1:0]   len_phase;

    assign len      = kvrp_pkg::clamp_len(i_byte);
    assign rem_dec  = (i_state.remaining == '0) ? '0 : i_state.remaining - 8'd1;
    assign lane     = i_state.position[kvrp_pkg::LANE_W-1:0];
    assign pos_inc  = {1'b0, i_state.position} + 9'd1;
    assign val_last = pos_inc >= {5'd0, kvrp_pkg::eff_vbytes(i_vbytes)};
    // an unused phase code falls back to the name length
    assign len_phase = (i_state.phase == kvrp_pkg::PH_UNIT_LEN ||
                        i_state.phase == kvrp_pkg::PH_DESC_LEN) ?
                       i_state.phase : kvrp_pkg::PH_NAME_LEN;

    // merge the byte into its lane of the value
    always_comb begin
        acc_new = i_state.acc;
        for (int k = 0; k < kvrp_pkg::LANES; k++) begin
            if (lane == k[kvrp_pkg::LANE_W-1:0]) begin
                acc_new[k*kvrp_pkg::BYTE_W +: kvrp_pkg::BYTE_W] =
                    i_state.acc[k*kvrp_pkg::BYTE_W +: kvrp_pkg::BYTE_W] | i_byte;
            end
        end
    end

    always_comb begin
        o_next = i_state;
        o_res.field_kind   = i_state.phase;
        o_res.data_byte    = i_byte;
        o_res.byte_index   = '0;
        o_res.value_done   = 1'b0;
        o_res.record_value = '0;
        o_res.record_end   = 1'b0;
        case (i_state.phase)
            kvrp_pkg::PH_NAME, kvrp_pkg::PH_UNIT, kvrp_pkg::PH_DESC: begin
                o_res.byte_index = i_state.position;
                o_next.position  = i_state.position + 8'd1;
                o_next.remaining = rem_dec;
                if (rem_dec == '0) begin
                    o_next.position = '0;
                    if (i_state.phase == kvrp_pkg::PH_NAME) begin
                        o_next.phase = kvrp_pkg::PH_VALUE;
                        o_next.acc   = '0;
                    end else if (i_state.phase == kvrp_pkg::PH_UNIT) begin
                        o_next.phase = kvrp_pkg::PH_DESC_LEN;
                    end else begin
                        o_res.record_end = 1'b1;
                        o_next.phase     = kvrp_pkg::PH_NAME_LEN;
                    end
                end
            end
            kvrp_pkg::PH_VALUE: begin
                o_res.byte_index = {{(kvrp_pkg::BYTE_W-kvrp_pkg::LANE_W){1'b0}}, lane};
                o_next.acc       = acc_new;
                if (val_last) begin
                    o_res.value_done   = 1'b1;
                    o_res.record_value = acc_new;
                    o_next.phase       = kvrp_pkg::PH_UNIT_LEN;
                    o_next.position    = '0;
                end else begin
                    o_next.position = pos_inc[kvrp_pkg::BYTE_W-1:0];
                end
            end
            default: begin
                o_res.field_kind = len_phase;
                o_res.data_byte  = len;
                o_next.position  = '0;
                o_next.remaining = len;
                if (len != '0) begin
                    o_next.phase = len_phase + 3'd1;
                end else if (len_phase == kvrp_pkg::PH_NAME_LEN) begin
                    // empty name: straight on to the value
                    o_next.phase     = kvrp_pkg::PH_VALUE;
                    o_next.remaining = '0;
                    o_next.acc       = '0;
                end else if (len_phase == kvrp_pkg::PH_UNIT_LEN) begin
                    o_next.phase = kvrp_pkg::PH_DESC_LEN;
                end else begin
                    o_res.record_end = 1'b1;
                    o_next.phase     = kvrp_pkg::PH_NAME_LEN;
                end
            end
        endcase
    end

endmodule

[hdl/key_value_record_byte_parser_unit.sv]
// Top level of the key/value record byte parser: state and result registers.
// Depends on kvrp_pkg, kvrp_in_if, kvrp_out_if and kvrp_step.
//
//  channel   dir  handshake      word
//  i_byte    in   valid/ready    in_byte: one stream byte
//  o_rec     out  valid/ready    field_kind, data_byte, byte_index, value_done,
//                                record_value, record_end
//  cfg       in   i_cfg_we       i_cfg_wdata: value size in bytes
//
// One byte per cycle unless o_rec stalls; each result is registered and shows
// on o_rec the cycle after its byte; the state loop closes through kvrp_step.
// A new byte enters in the cycle the waiting result is taken, so words stream
// back to back; a stall on o_rec holds i_byte.ready low while the result
// register is full.
// Synchronous active-low reset; parsing starts at a name length, size 2.
module key_value_record_byte_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kvrp_pkg::VBYTE_W-1:0]     i_cfg_wdata,
    kvrp_in_if.sink                          i_byte,
    kvrp_out_if.source                       o_rec
);

    kvrp_pkg::t_state                  r_state;
    kvrp_pkg::t_state                  n_state;
    kvrp_pkg::t_result                 r_res;
    kvrp_pkg::t_result                 n_res;
    logic                              r_valid;
    logic [kvrp_pkg::VBYTE_W-1:0]      r_vbytes;
    logic                              in_ready;
    logic                              accept;

    assign in_ready = !r_valid || o_rec.ready;
    assign accept   = i_byte.valid && in_ready;

    kvrp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_byte.in_byte),
        .i_vbytes (r_vbytes),
        .o_next   (n_state),
        .o_res    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_valid  <= 1'b0;
            r_vbytes <= kvrp_pkg::VBYTES_RESET;
        end else begin
            if (i_cfg_we) begin
                r_vbytes <= i_cfg_wdata;
            end
            if (accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (o_rec.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign i_byte.ready       = in_ready;
    assign o_rec.valid        = r_valid;
    assign o_rec.field_kind   = r_res.field_kind;
    assign o_rec.data_byte    = r_res.data_byte;
    assign o_rec.byte_index   = r_res.byte_index;
    assign o_rec.value_done   = r_res.value_done;
    assign o_rec.record_value = r_res.record_value;
    assign o_rec.record_end   = r_res.record_end;

endmodule

[hdl/kvrp_checker.sv]
// Port-level checks for the record parser, bound to its top level.
// Depends on kvrp_pkg and key_value_record_byte_parser_unit.
module kvrp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [kvrp_pkg::KIND_W-1:0]  i_kind,
    input logic [kvrp_pkg::BYTE_W-1:0]  i_data,
    input logic                         i_vdone,
    input logic [kvrp_pkg::VALUE_W-1:0] i_value,
    input logic                         i_rend
);

    // only the completing value byte carries a value
    a_value_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_vdone |-> i_value == '0)
        else $error("record_value set without value_done");

    a_done_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_vdone |-> i_kind == kvrp_pkg::PH_VALUE)
        else $error("value_done on a non-value byte");

    a_end_in_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rend |->
            (i_kind == kvrp_pkg::PH_DESC || i_kind == kvrp_pkg::PH_DESC_LEN))
        else $error("record_end outside the description");

    a_len_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == kvrp_pkg::PH_NAME_LEN || i_kind == kvrp_pkg::PH_UNIT_LEN ||
                    i_kind == kvrp_pkg::PH_DESC_LEN) |-> i_data <= kvrp_pkg::MAX_STR_LEN)
        else $error("length above limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_data) &&
                                $stable(i_value))
        else $error("result word changed while stalled");

endmodule

bind key_value_record_byte_parser_unit kvrp_checker u_kvrp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rec.valid),
    .i_ready (o_rec.ready),
    .i_kind  (o_rec.field_kind),
    .i_data  (o_rec.data_byte),
    .i_vdone (o_rec.value_done),
    .i_value (o_rec.record_value),
    .i_rend  (o_rec.record_end)
);

[bench/kvrp_record_checker.sv]
// Checker for the key/value record byte parser: watches both channels and the size register.
// Predicts one result per accepted byte and compares it with the result words.
// Depends on kvrp_pkg, kvrp_in_if and kvrp_out_if.
`timescale 1ns / 100ps

module kvrp_record_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [kvrp_pkg::VBYTE_W-1:0] i_cfg_wdata,
    kvrp_in_if                           i_byte,
    kvrp_out_if                          i_rec,
    output int                           o_fail_count,
    output int                           o_pending
);
    import kvrp_pkg::*;

    logic [KIND_W-1:0]  parse_phase;
    logic [BYTE_W-1:0]  left_in_string;
    logic [BYTE_W-1:0]  field_pos;
    logic [VALUE_W-1:0] value_acc;
    logic [VBYTE_W-1:0] value_size;

    t_result expected_results[$];
    int      fail_total = 0;
    int      queued = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = queued;

    function void start_value();
        parse_phase    = PH_VALUE;
        field_pos      = '0;
        left_in_string = '0;
        value_acc      = '0;
    endfunction

    // advance the parse state by one stream byte and return its tagged result
    function automatic t_result parse_byte(input logic [BYTE_W-1:0] b);
        t_result           r;
        logic [BYTE_W-1:0] len;
        int                size;
        r = '0;
        r.data_byte = b;
        case (parse_phase)
            PH_NAME, PH_UNIT, PH_DESC: begin
                r.field_kind = parse_phase;
                r.byte_index = field_pos;
                field_pos = field_pos + 1'b1;
                if (left_in_string != 0) left_in_string = left_in_string - 1'b1;
                if (left_in_string == 0) begin
                    field_pos = '0;
                    if (parse_phase == PH_NAME) begin
                        start_value();
                    end else if (parse_phase == PH_UNIT) begin
                        parse_phase = PH_DESC_LEN;
                    end else begin
                        r.record_end = 1'b1;
                        parse_phase = PH_NAME_LEN;
                    end
                end
            end
            PH_VALUE: begin
                // out-of-range sizes saturate to the nearest legal one
                size = (value_size < 2) ? 2 : (value_size > 8) ? 8 : int'(value_size);
                r.field_kind = PH_VALUE;
                r.byte_index = {5'd0, field_pos[2:0]};
                value_acc = value_acc | (VALUE_W'(b) << (8 * field_pos[2:0]));
                if (int'(field_pos) + 1 >= size) begin
                    r.value_done   = 1'b1;
                    r.record_value = value_acc;
                    parse_phase = PH_UNIT_LEN;
                    field_pos = '0;
                end else begin
                    field_pos = field_pos + 1'b1;
                end
            end
            default: begin
                if (parse_phase != PH_UNIT_LEN && parse_phase != PH_DESC_LEN)
                    parse_phase = PH_NAME_LEN;
                len = (b > MAX_STR_LEN) ? MAX_STR_LEN : b;
                r.field_kind = parse_phase;
                r.data_byte = len;
                field_pos = '0;
                left_in_string = len;
                if (len != 0) begin
                    parse_phase = parse_phase + 1'b1;
                end else if (parse_phase == PH_NAME_LEN) begin
                    start_value();
                end else if (parse_phase == PH_UNIT_LEN) begin
                    parse_phase = PH_DESC_LEN;
                end else begin
                    // empty description: the length byte closes the record
                    r.record_end = 1'b1;
                    parse_phase = PH_NAME_LEN;
                end
            end
        endcase
        return r;
    endfunction

    function void check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            parse_phase    = PH_NAME_LEN;
            left_in_string = '0;
            field_pos      = '0;
            value_acc      = '0;
            value_size     = VBYTES_RESET;
            expected_results.delete();
            queued = 0;
        end else begin
            if (i_rec.valid && i_rec.ready) begin
                got.field_kind   = i_rec.field_kind;
                got.data_byte    = i_rec.data_byte;
                got.byte_index   = i_rec.byte_index;
                got.value_done   = i_rec.value_done;
                got.record_value = i_rec.record_value;
                got.record_end   = i_rec.record_end;
                if (expected_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected word, expected none, actual %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("field_kind", 64'(want.field_kind), 64'(got.field_kind));
                    check_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
                    check_field("byte_index", 64'(want.byte_index), 64'(got.byte_index));
                    check_field("value_done", 64'(want.value_done), 64'(got.value_done));
                    check_field("record_value", want.record_value, got.record_value);
                    check_field("record_end", 64'(want.record_end), 64'(got.record_end));
                end
            end
            if (i_cfg_we) value_size = i_cfg_wdata;
            if (i_byte.valid && i_byte.ready)
                expected_results.push_back(parse_byte(i_byte.in_byte));
            queued = expected_results.size();
        end
    end

endmodule

[bench/key_value_record_byte_parser_unit_tb.sv]
// Testbench top for the key/value record byte parser: clock, reset, record stimulus, verdict.
// Instantiates the parser beside kvrp_record_checker, which does all prediction and comparison.
// Depends on kvrp_pkg, kvrp_in_if, kvrp_out_if and the parser RTL.
`timescale 1ns / 100ps

module key_value_record_byte_parser_unit_tb;
    import kvrp_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 300000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [VBYTE_W-1:0] cfg_wdata;
    logic [VBYTE_W-1:0] size_cur;

    int fail_count;
    int pending;
    int sent = 0;
    int cycles = 0;
    bit idle_on = 1'b1;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    logic [VBYTE_W-1:0] size_plan [11] = '{4'd15, 4'd0, 4'd8, 4'd3, 4'd1, 4'd5,
                                           4'd9, 4'd2, 4'd6, 4'd7, 4'd4};

    kvrp_in_if  byte_ch ();
    kvrp_out_if rec_ch ();

    key_value_record_byte_parser_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_byte      (byte_ch),
        .o_rec       (rec_ch)
    );

    kvrp_record_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_byte       (byte_ch),
        .i_rec        (rec_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus a counted hold-off on request
    always @(negedge clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            rec_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rec_ch.ready <= 1'b0;
        end else begin
            rec_ch.ready <= !idle_on || ($urandom_range(99) >= 34);
        end
    end

    // entered and left at a falling edge; valid stays high for the next word
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while (idle_on && $urandom_range(99) < 34) begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // hold the sender until every result is back, then let the last one settle
    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_size(input logic [VBYTE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        size_cur = v;
    endtask

    task automatic send_string(input logic [BYTE_W-1:0] len_byte);
        int n;
        n = (len_byte > MAX_STR_LEN) ? int'(MAX_STR_LEN) : int'(len_byte);
        push_byte(len_byte);
        repeat (n) push_byte(BYTE_W'($urandom_range(255)));
    endtask

    // one record; a split above zero and below the value size changes the value size after that many value bytes
    task automatic send_record(input logic [BYTE_W-1:0] name_len, input logic [BYTE_W-1:0] unit_len,
                               input logic [BYTE_W-1:0] desc_len, input logic [VALUE_W-1:0] value,
                               input int split, input logic [VBYTE_W-1:0] next_size);
        int eff;
        int count;
        int k;
        send_string(name_len);
        eff = (size_cur < 2) ? 2 : (size_cur > 8) ? 8 : int'(size_cur);
        count = eff;
        k = 0;
        if (split > 0 && split < eff) begin
            repeat (split) begin
                push_byte(value[8*k +: 8]);
                k++;
            end
            drain();
            write_size(next_size);
            eff = (size_cur < 2) ? 2 : (size_cur > 8) ? 8 : int'(size_cur);
            count = (eff > split) ? eff - split : 1;
        end else begin
            count = eff;
        end
        repeat (count) begin
            push_byte(value[8*k +: 8]);
            k++;
        end
        send_string(unit_len);
        send_string(desc_len);
    endtask

    function automatic logic [BYTE_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 12) return 8'd0;
        if (r < 92) return BYTE_W'($urandom_range(6, 1));
        if (r < 99) return BYTE_W'($urandom_range(40, 7));
        return BYTE_W'($urandom_range(255, 200));
    endfunction

    initial begin : stimulus
        int ph;
        int phase_end;
        int eff;
        logic [VBYTE_W-1:0] next_size;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = '0;
        rec_ch.ready    = 1'b0;
        size_cur        = VBYTES_RESET;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty strings throughout; the description length ends the record
        send_record(8'd0, 8'd0, 8'd0, 64'h0000_0000_0000_FF00, 0, '0);
        send_record(8'd1, 8'd2, 8'd1, 64'h0000_0000_0000_5AA5, 0, '0);
        drain();
        write_size(4'd8);
        // shrink the size part way through an eight-byte value
        send_record(8'd0, 8'd0, 8'd0, 64'hFFFF_FFFF_FF80_0001, 5, 4'd3);

        ph = 0;
        while (sent < ITEM_TARGET) begin
            next_size = (ph < 11) ? size_plan[ph] : VBYTE_W'($urandom_range(15));
            eff = (size_cur < 2) ? 2 : (size_cur > 8) ? 8 : int'(size_cur);
            if (eff > 2 && $urandom_range(1) == 1) begin
                send_record(pick_len(), pick_len(), pick_len(), {$urandom, $urandom},
                            $urandom_range(eff - 1, 1), next_size);
            end else begin
                drain();
                write_size(next_size);
            end
            idle_on <= (ph != 3);
            if (ph == 2) hold_seq <= hold_seq + 1;
            // longest strings: an over-limit name length and an exactly-at-limit unit
            if (ph == 1)
                send_record(8'd255, 8'd254, 8'd0, {$urandom, $urandom}, 0, '0);
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end)
                send_record(pick_len(), pick_len(), pick_len(), {$urandom, $urandom}, 0, '0);
            ph++;
        end

        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
